// ----- rtl/mxf_universal_label_classifier_defines.svh -----
// Assertion macros for the MXF universal label classifier.
// Each macro expects clk and rst to be visible at the point of use.
`ifndef MXF_UNIVERSAL_LABEL_CLASSIFIER_DEFINES_SVH
`define MXF_UNIVERSAL_LABEL_CLASSIFIER_DEFINES_SVH

// Same-cycle implication.
`define MXF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MXF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/mxfulc_pkg.sv -----
// Types and byte-match constants for the MXF universal label classifier.
// No dependencies.
`timescale 1ns / 1ps

package mxfulc_pkg;

  typedef enum logic [3:0] {
    CLS_NOT_MXF    = 4'd0,
    CLS_OTHER      = 4'd1,
    CLS_HEADER     = 4'd2,
    CLS_BODY       = 4'd3,
    CLS_FOOTER     = 4'd4,
    CLS_FILL       = 4'd5,
    CLS_PRIMER     = 4'd6,
    CLS_METADATA   = 4'd7,
    CLS_DESCRIPT   = 4'd8,
    CLS_RIP        = 4'd9,
    CLS_INDEX      = 4'd10,
    CLS_SYSTEM     = 4'd11,
    CLS_ESSENCE    = 4'd12,
    CLS_CONTAINER  = 4'd13
  } label_class_t;

  localparam logic [31:0] MXF_PREFIX = 32'h060e2b34;

  // Bytes 0..7 and 8..12 of the partition pack family
  localparam logic [63:0] PP_STEM_HI = 64'h060e2b3402050101;
  localparam logic [39:0] PP_STEM_LO = 40'h0d01020101;

  // Bytes 0..7 and 8..12 of structural metadata sets
  localparam logic [63:0] MD_STEM_HI = 64'h060e2b3402530101;
  localparam logic [39:0] MD_STEM_LO = 40'h0d01010101;

  localparam logic [63:0] FILL_HI  = 64'h060e2b3401010101;
  localparam logic [63:0] FILL_LO  = 64'h0301021001000000;
  localparam logic [63:0] INDEX_HI = 64'h060e2b3402530101;
  localparam logic [63:0] INDEX_LO = 64'h0d01020101100100;

  localparam logic [7:0] PP_KIND_HEADER = 8'h02;
  localparam logic [7:0] PP_KIND_FOOTER = 8'h04;
  localparam logic [7:0] PP_KIND_PRIMER = 8'h05;
  localparam logic [7:0] PP_KIND_RIP    = 8'h11;
  localparam logic [7:0] PP_STATUS_LIM  = 8'h05;

  localparam logic [7:0] STATUS_CLOSED          = 8'h02;
  localparam logic [7:0] STATUS_COMPLETE        = 8'h03;
  localparam logic [7:0] STATUS_CLOSED_COMPLETE = 8'h04;

endpackage

// ----- rtl/mxf_universal_label_classifier.sv -----
// Each request goes through the input register, then the result register.
// One key per cycle when not stalled; classification is one pass of byte compares.
// in_stall follows out_stall only when both stages hold a request.
// Reset clears the stage valid flags; key and result payload registers are not reset.
// Depends on mxfulc_pkg and mxf_universal_label_classifier_defines.svh.
`timescale 1ns / 1ps
`include "mxf_universal_label_classifier_defines.svh"

module mxf_universal_label_classifier
  import mxfulc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] key_high,
  input  logic [63:0] key_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  label_class,
  output logic        partition_closed,
  output logic        partition_complete,
  output logic        label_is_zero,
  output logic [31:0] label_hash
);

  logic        stage_valid;
  logic [63:0] stage_key_high;
  logic [63:0] stage_key_low;
  logic        out_ready;
  logic        stage_ready;
  logic        stage_load;
  logic        out_load;

  logic [7:0]   b4, b5, b6, b7, b8, b9, b10, b11, b12, b13, b14, b15;
  logic         prefix_ok;
  logic         pp_stem;
  logic         md_stem;
  logic         gc_common;
  label_class_t class_next;

  assign out_ready   = !out_valid || !out_stall;
  assign stage_ready = !stage_valid || out_ready;
  assign in_stall    = !stage_ready;
  assign stage_load  = in_valid && stage_ready;
  assign out_load    = stage_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (stage_ready) begin
        stage_valid <= in_valid;
      end
      if (out_ready) begin
        out_valid <= stage_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stage_load) begin
      stage_key_high <= key_high;
      stage_key_low  <= key_low;
    end
  end

  assign b4  = stage_key_high[31:24];
  assign b5  = stage_key_high[23:16];
  assign b6  = stage_key_high[15:8];
  assign b7  = stage_key_high[7:0];
  assign b8  = stage_key_low[63:56];
  assign b9  = stage_key_low[55:48];
  assign b10 = stage_key_low[47:40];
  assign b11 = stage_key_low[39:32];
  assign b12 = stage_key_low[31:24];
  assign b13 = stage_key_low[23:16];
  assign b14 = stage_key_low[15:8];
  assign b15 = stage_key_low[7:0];

  assign prefix_ok = (stage_key_high[63:32] == MXF_PREFIX);
  assign pp_stem   = (stage_key_high == PP_STEM_HI) && (stage_key_low[63:24] == PP_STEM_LO);
  assign md_stem   = (stage_key_high == MD_STEM_HI) && (stage_key_low[63:24] == MD_STEM_LO);
  // Bytes 6 and 8..11 shared by the generic container keys
  assign gc_common = (b6 == 8'h01) && (b8 == 8'h0d) && (b9 == 8'h01) &&
                     (b10 == 8'h03) && (b11 == 8'h01);

  always_comb begin
    priority if (!prefix_ok) begin
      class_next = CLS_NOT_MXF;
    end else if (pp_stem && (b13 >= PP_KIND_HEADER) && (b13 <= PP_KIND_FOOTER) &&
                 (b14 < PP_STATUS_LIM) && (b15 == 8'h00)) begin
      class_next = label_class_t'(b13[3:0]);
    end else if (pp_stem && (b13 == PP_KIND_PRIMER) && (b14 == 8'h01) &&
                 (b15 == 8'h00)) begin
      class_next = CLS_PRIMER;
    end else if (pp_stem && (b13 == PP_KIND_RIP) && (b14 == 8'h01) &&
                 (b15 == 8'h00)) begin
      class_next = CLS_RIP;
    end else if ((stage_key_high == FILL_HI) && (stage_key_low == FILL_LO)) begin
      class_next = CLS_FILL;
    end else if (md_stem && (b15 == 8'h00)) begin
      class_next = CLS_METADATA;
    end else if ((stage_key_high == INDEX_HI) && (stage_key_low == INDEX_LO)) begin
      class_next = CLS_INDEX;
    end else if ((b4 == 8'h02) && (b6 == 8'h01) && (b7 == 8'h01) && (b8 == 8'h0d) &&
                 (b9 == 8'h01) && (b10 == 8'h04) && (b11 == 8'h01)) begin
      class_next = CLS_DESCRIPT;
    end else if ((b4 == 8'h02) && gc_common &&
                 ((b12 == 8'h04) || (b12 == 8'h14))) begin
      class_next = CLS_SYSTEM;
    end else if ((b4 == 8'h01) && (b5 == 8'h02) && gc_common &&
                 ((b12 == 8'h05) || (b12 == 8'h06) || (b12 == 8'h07) ||
                  (b12 == 8'h15) || (b12 == 8'h16) || (b12 == 8'h17) ||
                  (b12 == 8'h18))) begin
      class_next = CLS_ESSENCE;
    end else if ((b4 == 8'h04) && (b5 == 8'h01) && gc_common &&
                 ((b12 == 8'h01) || (b12 == 8'h02))) begin
      class_next = CLS_CONTAINER;
    end else begin
      class_next = CLS_OTHER;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      label_class        <= class_next;
      partition_closed   <= (b14 == STATUS_CLOSED) || (b14 == STATUS_CLOSED_COMPLETE);
      partition_complete <= (b14 == STATUS_COMPLETE) || (b14 == STATUS_CLOSED_COMPLETE);
      label_is_zero      <= (stage_key_high == 64'd0) && (stage_key_low == 64'd0);
      label_hash         <= stage_key_high[63:32] ^ stage_key_high[31:0] ^
                            stage_key_low[63:32] ^ stage_key_low[31:0];
    end
  end

  `MXF_ASSERT_NOW(a_stall_only_when_full, in_stall, stage_valid && out_valid && out_stall, "input stalled with room in the pipeline")
  `MXF_ASSERT_NEXT(a_stage_moves_to_out, out_load, out_valid, "request lost between stages")
  `MXF_ASSERT_NEXT(a_stage_held, stage_valid && !out_ready, stage_valid, "blocked request dropped from input stage")
  `MXF_ASSERT_NOW(a_zero_not_mxf, out_valid && label_is_zero, label_class == CLS_NOT_MXF, "zero label classed as MXF")

endmodule

// ----- tb/mxf_universal_label_classifier_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for mxf_universal_label_classifier: directed and random KLV keys,
// predicted in the bench and checked field by field on the result channel.
// Depends on mxfulc_pkg and the classifier RTL.

module mxf_universal_label_classifier_tb;
  import mxfulc_pkg::*;

  localparam logic [31:0]  UL_PREFIX     = 32'h060e2b34;
  localparam logic [103:0] PARTITION_UL  = 104'h060e2b34020501010d01020101;
  localparam logic [103:0] STRUCT_MD_UL  = 104'h060e2b34025301010d01010101;
  localparam logic [127:0] FILL_UL       = 128'h060e2b34010101010301021001000000;
  localparam logic [127:0] INDEX_UL      = 128'h060e2b34025301010d01020101100100;
  localparam int           KEYS_PER_PHASE = 383;
  localparam int           MAX_REPORTS    = 40;

  typedef struct packed {
    label_class_t cls;
    logic         closed;
    logic         complete;
    logic         zero;
    logic [31:0]  hash;
  } label_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] key_high = '0;
  logic [63:0] key_low = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [3:0]  label_class;
  logic        partition_closed;
  logic        partition_complete;
  logic        label_is_zero;
  logic [31:0] label_hash;

  logic [127:0]  pending_keys [$];
  label_result_t expected_labels [$];
  int            keys_queued = 0;
  int            keys_taken = 0;
  int            errors = 0;
  int            send_idle_pct = 0;
  int            recv_stall_pct = 0;
  bit            req_taken = 1'b0;

  mxf_universal_label_classifier dut (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .key_high           (key_high),
    .key_low            (key_low),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .label_class        (label_class),
    .partition_closed   (partition_closed),
    .partition_complete (partition_complete),
    .label_is_zero      (label_is_zero),
    .label_hash         (label_hash)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic label_class_t classify_label(input logic [127:0] key);
    logic [7:0] b [16];
    int i;
    for (i = 0; i < 16; i++) b[i] = key[127 - 8 * i -: 8];
    if (key[127:96] != UL_PREFIX) return CLS_NOT_MXF;
    if (key[127:24] == PARTITION_UL) begin
      if (b[13] >= 8'h02 && b[13] <= 8'h04 && b[14] < 8'h05 && b[15] == 8'h00)
        return label_class_t'(b[13][3:0]);
      if (b[13] == 8'h05 && b[14] == 8'h01 && b[15] == 8'h00) return CLS_PRIMER;
      if (b[13] == 8'h11 && b[14] == 8'h01 && b[15] == 8'h00) return CLS_RIP;
    end
    if (key == FILL_UL) return CLS_FILL;
    if (key[127:24] == STRUCT_MD_UL && b[15] == 8'h00) return CLS_METADATA;
    if (key == INDEX_UL) return CLS_INDEX;
    if (b[4] == 8'h02 && b[6] == 8'h01 && b[7] == 8'h01 && b[8] == 8'h0d &&
        b[9] == 8'h01 && b[10] == 8'h04 && b[11] == 8'h01)
      return CLS_DESCRIPT;
    if (b[4] == 8'h02 && b[6] == 8'h01 && b[8] == 8'h0d && b[9] == 8'h01 &&
        b[10] == 8'h03 && b[11] == 8'h01 && (b[12] == 8'h04 || b[12] == 8'h14))
      return CLS_SYSTEM;
    if (b[4] == 8'h01 && b[5] == 8'h02 && b[6] == 8'h01 && b[8] == 8'h0d &&
        b[9] == 8'h01 && b[10] == 8'h03 && b[11] == 8'h01 &&
        (b[12] == 8'h05 || b[12] == 8'h06 || b[12] == 8'h07 || b[12] == 8'h15 ||
         b[12] == 8'h16 || b[12] == 8'h17 || b[12] == 8'h18))
      return CLS_ESSENCE;
    if (b[4] == 8'h04 && b[5] == 8'h01 && b[6] == 8'h01 && b[8] == 8'h0d &&
        b[9] == 8'h01 && b[10] == 8'h03 && b[11] == 8'h01 &&
        (b[12] == 8'h01 || b[12] == 8'h02))
      return CLS_CONTAINER;
    return CLS_OTHER;
  endfunction

  function automatic label_result_t predict_label(input logic [127:0] key);
    label_result_t r;
    logic [7:0] status;
    status     = key[15:8];
    r.cls      = classify_label(key);
    r.closed   = (status == 8'h02 || status == 8'h04);
    r.complete = (status == 8'h03 || status == 8'h04);
    r.zero     = (key == '0);
    r.hash     = key[127:96] ^ key[95:64] ^ key[63:32] ^ key[31:0];
    return r;
  endfunction

  // Build a well-formed key of the given class; bytes outside the match rules stay random.
  function automatic logic [127:0] build_key(input label_class_t kind);
    logic [7:0]   b [16];
    logic [127:0] key;
    int i;
    for (i = 0; i < 16; i++) b[i] = 8'($urandom);
    if (kind != CLS_NOT_MXF) {b[0], b[1], b[2], b[3]} = UL_PREFIX;
    // bias the status byte so the closed/complete flags show up often
    if ($urandom_range(1)) b[14] = 8'($urandom_range(0, 5));
    case (kind)
      CLS_HEADER, CLS_BODY, CLS_FOOTER: begin
        {b[4], b[5], b[6], b[7], b[8], b[9], b[10], b[11], b[12]} = PARTITION_UL[71:0];
        b[13] = 8'(kind);
        b[14] = 8'($urandom_range(0, 5));
        b[15] = 8'h00;
      end
      CLS_PRIMER, CLS_RIP: begin
        {b[4], b[5], b[6], b[7], b[8], b[9], b[10], b[11], b[12]} = PARTITION_UL[71:0];
        b[13] = (kind == CLS_PRIMER) ? 8'h05 : 8'h11;
        b[14] = 8'h01;
        b[15] = 8'h00;
      end
      CLS_METADATA: begin
        {b[4], b[5], b[6], b[7], b[8], b[9], b[10], b[11], b[12]} = STRUCT_MD_UL[71:0];
        b[15] = 8'h00;
      end
      CLS_DESCRIPT: begin
        b[4] = 8'h02;
        {b[6], b[7], b[8], b[9], b[10], b[11]} = 48'h01010d010401;
      end
      CLS_SYSTEM: begin
        b[4] = 8'h02;
        b[6] = 8'h01;
        {b[8], b[9], b[10], b[11]} = 32'h0d010301;
        b[12] = $urandom_range(1) ? 8'h14 : 8'h04;
      end
      CLS_ESSENCE: begin
        {b[4], b[5], b[6]} = 24'h010201;
        {b[8], b[9], b[10], b[11]} = 32'h0d010301;
        case ($urandom_range(6))
          0: b[12] = 8'h05;
          1: b[12] = 8'h06;
          2: b[12] = 8'h07;
          3: b[12] = 8'h15;
          4: b[12] = 8'h16;
          5: b[12] = 8'h17;
          default: b[12] = 8'h18;
        endcase
      end
      CLS_CONTAINER: begin
        {b[4], b[5], b[6]} = 24'h040101;
        {b[8], b[9], b[10], b[11]} = 32'h0d010301;
        b[12] = $urandom_range(1) ? 8'h02 : 8'h01;
      end
      default: ;
    endcase
    for (i = 0; i < 16; i++) key[127 - 8 * i -: 8] = b[i];
    if (kind == CLS_FILL) key = FILL_UL;
    if (kind == CLS_INDEX) key = INDEX_UL;
    return key;
  endfunction

  // Mostly well-formed keys, some with one bit broken, the rest noise.
  function automatic logic [127:0] random_key();
    logic [127:0] key;
    int pick;
    int pos;
    pick = $urandom_range(99);
    pos  = $urandom_range(127);
    if (pick < 85) key = build_key(label_class_t'($urandom_range(2, 13)));
    else if (pick < 93) key = build_key(CLS_OTHER);
    else key = {$urandom, $urandom, $urandom, $urandom};
    if (pick >= 70 && pick < 85) key[pos] = ~key[pos];
    return key;
  endfunction

  task automatic queue_key(input logic [127:0] key);
    pending_keys.push_back(key);
    keys_queued++;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  task automatic wait_drained();
    while (!(keys_taken == keys_queued && expected_labels.size() == 0)) @(posedge clk);
  endtask

  // Driver: present the next request once the current one is taken.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || req_taken) begin
      if (pending_keys.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        {key_high, key_low} <= pending_keys.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Monitor: predict on request accept, check on result accept.
  always @(posedge clk) begin
    label_result_t want;
    req_taken = in_valid && !in_stall;
    if (!rst && req_taken) begin
      expected_labels.push_back(predict_label({key_high, key_low}));
      keys_taken++;
    end
    if (!rst && out_valid && !out_stall) begin
      if (expected_labels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual class %0d hash 0x%0h",
                   $time, label_class, label_hash);
      end else begin
        want = expected_labels.pop_front();
        check_field("label_class", 32'(want.cls), 32'(label_class));
        check_field("partition_closed", 32'(want.closed), 32'(partition_closed));
        check_field("partition_complete", 32'(want.complete), 32'(partition_complete));
        check_field("label_is_zero", 32'(want.zero), 32'(label_is_zero));
        check_field("label_hash", want.hash, label_hash);
      end
    end
  end

  initial begin
    int phase;
    int n;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed keys: extremes, one of each class, partition and metadata corner cases
    queue_key('0);
    queue_key('1);
    queue_key({UL_PREFIX, 96'h0});
    for (n = int'(CLS_HEADER); n <= int'(CLS_CONTAINER); n++)
      queue_key(build_key(label_class_t'(n)));
    queue_key({PARTITION_UL, 24'h020400});
    queue_key({PARTITION_UL, 24'h030200});
    queue_key({PARTITION_UL, 24'h040300});
    queue_key({PARTITION_UL, 24'h020500});
    queue_key({PARTITION_UL, 24'h030201});
    queue_key({PARTITION_UL, 24'h050200});
    queue_key({STRUCT_MD_UL, 24'h0102ff});
    queue_key({PARTITION_UL, 24'h1101ff});
    wait_drained();

    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 77; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 77; end
        default: begin send_idle_pct = 25; recv_stall_pct = 25; end
      endcase
      for (n = 0; n < KEYS_PER_PHASE; n++) queue_key(random_key());
      // hold off new requests until every result of this phase is back
      wait_drained();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("** mxf_universal_label_classifier: PASSED **");
    end else begin
      $display("** mxf_universal_label_classifier: FAILED **");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout at %0t", $time);
    $display("** mxf_universal_label_classifier: FAILED **");
    $finish;
  end

endmodule
